// ===== design/iee_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iee_pkg
// Shared widths, character codes, types and helpers of the infix evaluator.
// ---------------------------------------------------------------------------
package iee_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int OUT_BITS       = 32;
    localparam int CH_BITS        = 8;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 1 + 7) / 8) * 8;
    localparam int DIV_CNT_BITS   = $clog2(VALUE_BITS);

    localparam logic [CH_BITS-1:0] CH_EQUALS = 8'h3D;
    localparam logic [CH_BITS-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_BITS-1:0] CH_STAR   = 8'h2A;
    localparam logic [CH_BITS-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CH_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [3:0]         RADIX     = 4'd10;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_MUL  = 2'd1,
        OP_DIV  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        CLS_DIGIT  = 3'd0,
        CLS_MULDIV = 3'd1,
        CLS_ADDSUB = 3'd2,
        CLS_EQUALS = 3'd3,
        CLS_OTHER  = 3'd4
    } t_cls;

    typedef struct packed {
        logic accept;
        logic digit;
        logic clear;
        logic close;
        logic apply_op;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic in_last;
        logic skipping;
        logic op_is_div;
        logic div_done;
        logic out_busy;
        logic held_last;
    } t_stat;

    function automatic t_cls classify(input logic [CH_BITS-1:0] ch);
        t_cls c;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            c = CLS_DIGIT;
        end else if (ch == CH_STAR || ch == CH_SLASH) begin
            c = CLS_MULDIV;
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            c = CLS_ADDSUB;
        end else if (ch == CH_EQUALS) begin
            c = CLS_EQUALS;
        end else begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

endpackage

// ===== design/iee_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iee_div
// Signed restoring divider, one quotient bit per cycle, truncates to zero.
// ---------------------------------------------------------------------------
module iee_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [iee_pkg::VALUE_BITS-1:0]     i_dividend,
    input  logic [iee_pkg::VALUE_BITS-1:0]     i_divisor,
    output logic                               o_done,
    output logic [iee_pkg::VALUE_BITS-1:0]     o_quot,
    output logic                               o_zero
);

    localparam int VB = iee_pkg::VALUE_BITS;

    logic                                r_busy, n_busy;
    logic                                r_done, n_done;
    logic [iee_pkg::DIV_CNT_BITS-1:0]    r_cnt, n_cnt;
    logic [VB:0]                         r_rem, n_rem;
    logic [VB-1:0]                       r_quo, n_quo;
    logic [VB-1:0]                       r_dvs, n_dvs;
    logic                                r_neg, n_neg;
    logic                                r_zero, n_zero;

    logic [VB:0]                         w_shift;
    logic [VB:0]                         w_diff;

    assign w_shift = {r_rem[VB-1:0], r_quo[VB-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        n_zero = r_zero;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend[VB-1] ? VB'(-i_dividend) : i_dividend;
            n_dvs  = i_divisor[VB-1] ? VB'(-i_divisor) : i_divisor;
            n_neg  = i_dividend[VB-1] ^ i_divisor[VB-1];
            n_zero = (i_divisor == '0);
        end else if (r_busy) begin
            if (!w_diff[VB]) begin
                n_rem = w_diff;
                n_quo = {r_quo[VB-2:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[VB-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == iee_pkg::DIV_CNT_BITS'(VB - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dvs  <= n_dvs;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    assign o_done = r_done;
    assign o_zero = r_zero;
    assign o_quot = r_zero ? '0 : (r_neg ? VB'(-r_quo) : r_quo);

endmodule

// ===== design/iee_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iee_dp
// Evaluator datapath: number, term and sum registers, divider, result beat.
// ---------------------------------------------------------------------------
module iee_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  iee_pkg::t_cmd                         i_cmd,
    output iee_pkg::t_stat                        o_stat,
    input  logic [iee_pkg::CH_BITS-1:0]           i_ch,
    input  logic                                  i_last,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic [iee_pkg::OUT_BITS-1:0]          o_out_value,
    output logic                                  o_out_status
);

    localparam int VB = iee_pkg::VALUE_BITS;

    logic [VB-1:0]                  r_sum;
    logic [VB-1:0]                  r_pend;
    logic [VB-1:0]                  r_cur;
    logic [VB-1:0]                  r_term;
    iee_pkg::t_op                   r_op;
    logic                           r_sign;
    logic                           r_skip;
    logic                           r_err;
    logic [iee_pkg::CH_BITS-1:0]    r_ch;
    logic                           r_last;
    logic                           r_out_valid;
    logic [iee_pkg::OUT_BITS-1:0]   r_out_value;
    logic                           r_out_status;

    logic [VB-1:0]                  w_mul;
    logic [VB-1:0]                  w_fold;
    logic [VB-1:0]                  w_next_digit;
    logic [3:0]                     w_digit;
    logic                           w_clear;
    logic                           w_div_start;
    logic                           w_div_done;
    logic                           w_div_zero;
    logic [VB-1:0]                  w_div_quot;
    logic signed [VB-1:0]           w_fold_s;

    assign w_mul        = VB'(r_pend * r_cur);
    assign w_fold       = r_sign ? (r_sum - r_term) : (r_sum + r_term);
    assign w_fold_s     = w_fold;
    assign w_digit      = 4'(i_ch - iee_pkg::CH_ZERO);
    assign w_next_digit = VB'(r_cur * iee_pkg::RADIX) + VB'(w_digit);
    assign w_clear      = i_cmd.clear || (i_cmd.finish && r_last);
    assign w_div_start  = i_cmd.close && (r_op == iee_pkg::OP_DIV);

    iee_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_pend),
        .i_divisor  (r_cur),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_zero     (w_div_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_sum  <= '0;
            r_pend <= '0;
            r_cur  <= '0;
            r_op   <= iee_pkg::OP_NONE;
            r_sign <= 1'b0;
            r_skip <= 1'b0;
            r_err  <= 1'b0;
        end else begin
            if (i_cmd.digit) begin
                r_cur <= w_next_digit;
            end
            if (i_cmd.close) begin
                r_cur <= '0;
                r_op  <= iee_pkg::OP_NONE;
            end
            if (w_div_done && w_div_zero) begin
                r_err <= 1'b1;
            end
            if (i_cmd.apply_op) begin
                if (r_ch == iee_pkg::CH_STAR || r_ch == iee_pkg::CH_SLASH) begin
                    r_pend <= r_term;
                    r_op   <= (r_ch == iee_pkg::CH_STAR) ? iee_pkg::OP_MUL
                                                         : iee_pkg::OP_DIV;
                end else begin
                    r_sum  <= w_fold;
                    r_sign <= (r_ch == iee_pkg::CH_MINUS);
                end
            end
            if (i_cmd.finish) begin
                r_sum  <= w_fold;
                r_sign <= 1'b0;
                r_skip <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
        if (i_cmd.close && r_op != iee_pkg::OP_DIV) begin
            r_term <= (r_op == iee_pkg::OP_MUL) ? w_mul : r_cur;
        end else if (w_div_done) begin
            r_term <= w_div_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_out_value  <= iee_pkg::OUT_BITS'(w_fold_s);
            r_out_status <= r_err;
        end
    end

    always_comb begin
        o_stat.cls       = iee_pkg::classify(i_ch);
        o_stat.in_last   = i_last;
        o_stat.skipping  = r_skip;
        o_stat.op_is_div = (r_op == iee_pkg::OP_DIV);
        o_stat.div_done  = w_div_done;
        o_stat.out_busy  = r_out_valid && !i_out_ready;
        o_stat.held_last = r_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_status = r_out_status;

endmodule

// ===== design/iee_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iee_ctrl
// Evaluator controller: input handshake and sequencing of term closing.
// ---------------------------------------------------------------------------
module iee_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  iee_pkg::t_stat  i_stat,
    output iee_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CLOSE = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_APPLY = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_fin, n_fin;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.skipping) begin
                        o_cmd.clear = i_stat.in_last;
                    end else begin
                        unique case (i_stat.cls)
                            iee_pkg::CLS_DIGIT: begin
                                o_cmd.digit = 1'b1;
                                n_fin       = 1'b1;
                                if (i_stat.in_last) begin
                                    n_state = ST_CLOSE;
                                end
                            end
                            iee_pkg::CLS_MULDIV, iee_pkg::CLS_ADDSUB: begin
                                n_fin   = 1'b0;
                                n_state = ST_CLOSE;
                            end
                            iee_pkg::CLS_EQUALS: begin
                                n_fin   = 1'b1;
                                n_state = ST_CLOSE;
                            end
                            default: begin
                                n_fin = 1'b1;
                                if (i_stat.in_last) begin
                                    n_state = ST_CLOSE;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_CLOSE: begin
                o_cmd.close = 1'b1;
                n_state     = i_stat.op_is_div ? ST_DIV : ST_APPLY;
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (r_fin) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    o_cmd.apply_op = 1'b1;
                    if (i_stat.held_last) begin
                        n_fin   = 1'b1;
                        n_state = ST_CLOSE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
        end
    end

endmodule

// ===== design/infix_expression_evaluator_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// infix_expression_evaluator_core
// Streaming evaluator of + - * / expressions over unsigned decimal operands.
// ---------------------------------------------------------------------------
// One ASCII character is taken per input beat. A digit or an ignored character
// not marked last, or any character after '=', leaves the input ready. An operator
// or the end of the expression closes the current term: the close step, a wait on
// the one-bit-per-cycle divider when the term ends in a division, then the apply
// step; an operator marked last closes twice. The result beat (value in bits 31:0,
// division-by-zero flag in bit 32) sits in an output register, so a stalled result
// holds the input side only when the next result is due.
module infix_expression_evaluator_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [iee_pkg::CH_BITS-1:0]            s_axis_tdata,  // [7:0] ch
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [iee_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata   // [31:0] value, [32] status
);

    iee_pkg::t_cmd                  w_cmd;
    iee_pkg::t_stat                 w_stat;
    logic [iee_pkg::OUT_BITS-1:0]   w_value;
    logic                           w_status;

    iee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    iee_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_ch         (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_value  (w_value),
        .o_out_status (w_status)
    );

    assign m_axis_tdata = {
        {(iee_pkg::OUT_TDATA_BITS - iee_pkg::OUT_BITS - 1){1'b0}}, w_status, w_value
    };

endmodule

// ===== design/iee_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iee_checker
// Port-level checks of the evaluator, bound to the top level.
// ---------------------------------------------------------------------------
module iee_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    input  logic                                   s_axis_tready,
    input  logic [iee_pkg::CH_BITS-1:0]            s_axis_tdata,
    input  logic                                   s_axis_tlast,
    input  logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic [iee_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[iee_pkg::OUT_TDATA_BITS-1:iee_pkg::OUT_BITS+1] == '0)
        else $error("result padding not zero");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a closing sequence");

    a_digit_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast &&
        s_axis_tdata >= iee_pkg::CH_ZERO && s_axis_tdata <= iee_pkg::CH_NINE
        |=> s_axis_tready)
        else $error("digit beat stalled the input");

endmodule

bind infix_expression_evaluator_core iee_checker u_iee_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
